// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash values and controller/datapath signals.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] r);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[r];
	endfunction

	function automatic word_t start_h(input logic [2:0] i);
		word_t h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	// byte source for a buffer write
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      buf_wr;      // write one byte at fill pointer
		byte_src_t src;
		logic [7:0] data;
		logic      fill_inc;    // advance fill pointer
		logic      fill_clr;
		logic      latch_total; // capture bit length
		logic      comp_start;  // begin 64-round compression
		logic      bits_add;    // count one completed block
		logic      restart;     // initial hash, clear bit counter
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       comp_busy;
		logic       comp_done;
	} dp_status_t;

endpackage

// ===== hdl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// sha_datapath: schedule window, counters and SHA-256 round unit
// Message bytes pack straight into the 16-word schedule window, big-endian.
// One round runs per cycle, and the schedule slides through the same window.
// ----------------------------------------------------------------------------
module sha_datapath
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  logic [2:0] rd_index,
	output word_t      rd_word,
	output dp_status_t status
);

	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  round_q;
	logic        busy_q;
	logic        done_q;
	logic [2:0]  lenb;
	logic [7:0]  wr_byte;
	word_t       w_new, t1, t2, s0, s1, e, a;

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign lenb = fill_q[2:0];
	always_comb begin
		unique case (cmd.src)
			SRC_DATA: wr_byte = cmd.data;
			SRC_MARK: wr_byte = PAD_MARK;
			SRC_ZERO: wr_byte = 8'h00;
			SRC_LEN:  wr_byte = total_q[(7 - lenb) * 8 +: 8];
			default:  wr_byte = 8'h00;
		endcase
	end

	always_comb begin
		e  = v_q[4];
		a  = v_q[0];
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + round_k(round_q) + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bits_q  <= '0;
			total_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= start_h(3'(i));
				v_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++)
				w_q[i] <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.fill_clr)
				fill_q <= '0;
			else if (cmd.fill_inc)
				fill_q <= fill_q + 6'd1;
			if (cmd.latch_total)
				total_q <= bits_q + {55'd0, fill_q, 3'd0};
			if (cmd.bits_add)
				bits_q <= bits_q + 64'd512;
			if (cmd.restart) begin
				bits_q <= '0;
				for (int i = 0; i < 8; i++)
					h_q[i] <= start_h(3'(i));
			end
			// bytes only arrive while the round unit is idle
			if (cmd.buf_wr)
				w_q[fill_q[5:2]][(3 - fill_q[1:0]) * 8 +: 8] <= wr_byte;
			if (cmd.comp_start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
				for (int i = 0; i < 8; i++)
					v_q[i] <= h_q[i];
			end else if (busy_q) begin
				// shift window: w_q[0] is this round's word
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= e;
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= a;
				v_q[0] <= t1 + t2;
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					h_q[0] <= h_q[0] + t1 + t2;
					h_q[1] <= h_q[1] + a;
					h_q[2] <= h_q[2] + v_q[1];
					h_q[3] <= h_q[3] + v_q[2];
					h_q[4] <= h_q[4] + v_q[3] + t1;
					h_q[5] <= h_q[5] + e;
					h_q[6] <= h_q[6] + v_q[5];
					h_q[7] <= h_q[7] + v_q[6];
				end
			end
		end
	end

	assign rd_word = h_q[rd_index];
	assign status  = '{fill: fill_q, comp_busy: busy_q, comp_done: done_q};

endmodule

// ===== hdl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for byte intake, padding, compression and output
// Pads one byte per cycle, waits out block passes; emits eight digest words.
// ----------------------------------------------------------------------------
module sha_ctrl
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  logic       in_bv,
	input  logic       in_last,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [2:0] out_index,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_WAIT, S_PAD1, S_PADZ, S_PADL, S_OUT
	} state_t;

	state_t     state_q;
	logic       fin_q;    // finish message after running compression
	logic       lenpass_q;// running the final block
	logic       spill_q;  // padding runs on into a second block
	logic [2:0] idx_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_index = idx_q;

	always_comb begin
		cmd = '0;
		cmd.data = in_byte;
		cmd.src  = SRC_DATA;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && in_bv) begin
					cmd.buf_wr   = 1'b1;
					cmd.fill_inc = (status.fill != 6'd63);
					cmd.fill_clr = (status.fill == 6'd63);
					cmd.comp_start = (status.fill == 6'd63);
					cmd.bits_add = (status.fill == 6'd63);
				end
			end
			S_PAD1: begin
				cmd.buf_wr = 1'b1;
				cmd.src    = SRC_MARK;
				cmd.fill_inc = (status.fill != 6'd63);
				cmd.fill_clr = (status.fill == 6'd63);
				cmd.comp_start = (status.fill == 6'd63);
			end
			S_PADZ: begin
				cmd.buf_wr = 1'b1;
				cmd.src    = SRC_ZERO;
				cmd.fill_inc = (status.fill != 6'd63);
				cmd.fill_clr = (status.fill == 6'd63);
				cmd.comp_start = (status.fill == 6'd63);
			end
			S_PADL: begin
				cmd.buf_wr = 1'b1;
				cmd.src    = SRC_LEN;
				cmd.fill_inc = (status.fill != 6'd63);
				cmd.fill_clr = (status.fill == 6'd63);
				cmd.comp_start = (status.fill == 6'd63);
			end
			S_OUT: cmd.restart = out_ready && (idx_q == 3'd7);
			S_WAIT: cmd.latch_total = !status.comp_busy && fin_q && !lenpass_q && !spill_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fin_q     <= 1'b0;
			lenpass_q <= 1'b0;
			spill_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					if (in_bv && status.fill == 6'd63) begin
						fin_q   <= in_last;
						state_q <= S_WAIT;
					end else if (in_last) begin
						fin_q   <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: if (!status.comp_busy && !cmd.comp_start) begin
					if (lenpass_q) begin
						lenpass_q <= 1'b0;
						idx_q     <= '0;
						state_q   <= S_OUT;
					end else if (spill_q) begin
						spill_q <= 1'b0;
						state_q <= S_PADZ;
					end else if (fin_q) begin
						fin_q   <= 1'b0;
						state_q <= S_PAD1;
					end else
						state_q <= S_IDLE;
				end
				S_PAD1: begin
					// total is taken on the cycle before the mark
					if (status.fill == 6'd63)
						state_q <= S_WAIT;
					else if (status.fill == 6'd55)
						state_q <= S_PADL;
					else
						state_q <= S_PADZ;
					if (status.fill == 6'd63)
						spill_q <= 1'b1;
				end
				S_PADZ: begin
					if (status.fill == 6'd63) begin
						spill_q <= 1'b1;
						state_q <= S_WAIT;
					end else if (status.fill == 6'd55)
						state_q <= S_PADL;
				end
				S_PADL: if (status.fill == 6'd63) begin
					lenpass_q <= 1'b1;
					state_q   <= S_WAIT;
				end
				S_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !status.comp_busy)
		else $error("digest shown during compression");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.comp_start |-> !status.comp_busy)
		else $error("compression restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PADL && status.fill == 6'd63) |=> (state_q == S_WAIT && lenpass_q))
		else $error("final block not tracked");

endmodule

// ===== hdl/sha256_stream_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash: streaming SHA-256 over a byte stream
// A request that fills no block and is not last keeps the input ready; the
// 64th byte of a block starts the round unit, which runs one round per cycle,
// and no further request is taken until it is done. A request marked last
// leads to a step that takes the bit length, then the padding bytes up to the
// block end and a 64-round pass; when fewer than nine bytes are left, the
// padding runs on through a whole second block with its own pass. Eight
// digest words then go out, H0 first.
// ----------------------------------------------------------------------------
module sha256_stream_hash
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [8] byte_valid, rest zero
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast   // last_word
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [2:0] idx;
	word_t      word;

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.in_byte(s_tdata[7:0]),
		.in_bv(s_tdata[8]),
		.in_last(s_tlast),
		.in_ready(s_tready),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_index(idx),
		.status, .cmd
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd,
		.rd_index(idx),
		.rd_word(word),
		.status
	);

	assign m_tdata = {5'd0, idx, word};
	assign m_tlast = (idx == 3'd7);

endmodule

// ===== bench/sha256_stream_hash_chk.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash_chk: digest predictor and output checker
// Watches the request and digest channels, hashes each accepted message byte
// stream in its own SHA-256 model, queues the eight expected digest words per
// message and compares every accepted output word against the oldest one.
// ----------------------------------------------------------------------------
module sha256_stream_hash_chk
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        fin;
	} digest_item_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	int           fill;
	logic [63:0]  done_bits;
	digest_item_t digest_q [$];

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		v = chain;
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				wr = s1 + w[(r-7)&15] + s0 + w[r&15];
				w[r&15] = wr;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wr;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic absorb_request(logic [15:0] d, logic fin);
		logic [63:0] total;
		int i;
		if (d[8]) begin
			blk[fill] = d[7:0];
			fill++;
			if (fill == 64) begin
				compress();
				done_bits += 64'd512;
				fill = 0;
			end
		end
		if (fin) begin
			total = done_bits + 64'(fill * 8);
			i = fill;
			blk[i] = PAD_MARK;
			i++;
			// length does not fit: flush an extra block
			if (fill >= 56) begin
				while (i < 64) begin
					blk[i] = 8'h00;
					i++;
				end
				compress();
				i = 0;
			end
			while (i < 56) begin
				blk[i] = 8'h00;
				i++;
			end
			for (int b = 0; b < 8; b++)
				blk[56+b] = total[63-8*b -: 8];
			compress();
			for (int b = 0; b < 8; b++)
				digest_q.push_back('{chain[b], 3'(b), b == 7});
			chain = H_INIT;
			fill = 0;
			done_bits = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_item_t e;
		if (!arst_n) begin
			chain = H_INIT;
			fill = 0;
			done_bits = '0;
			digest_q.delete();
			errors = 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_request(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", m_tdata[31:0]);
					errors++;
				end else begin
					e = digest_q.pop_front();
					if (m_tdata[31:0] !== e.word) begin
						$error("digest_word expected %h actual %h", e.word, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[34:32] !== e.idx) begin
						$error("word_index expected %0d actual %0d", e.idx, m_tdata[34:32]);
						errors++;
					end
					if (m_tlast !== e.fin) begin
						$error("last_word expected %b actual %b", e.fin, m_tlast);
						errors++;
					end
				end
			end
		end
		pending = digest_q.size();
	end

endmodule

// ===== bench/sha256_stream_hash_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash_tb: regression bench for the SHA-256 stream hasher
// Drives directed messages (empty, one byte, block boundaries, padding that
// spills into a second block, requests without a byte) and then random
// messages with random gaps and output stalls, including one long stall.
// ----------------------------------------------------------------------------
module sha256_stream_hash_tb;
	import sha_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	int          errors;
	int          pending;
	bit          long_hold = 1'b0;
	int          idle_cycles = 0;
	int          rx_wait = 0;

	always #5 clk = ~clk;

	sha256_stream_hash uut (.*);

	sha256_stream_hash_chk chk (.*);

	// send one request, with a random gap before it
	task automatic send(logic [7:0] b, logic bv, logic fin);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, bv, b};
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_message(int len, int noise);
		for (int i = 0; i < len; i++) begin
			if (noise > 0 && $urandom_range(0, noise) == 0)
				send(8'($urandom), 1'b0, 1'b0);
			send(8'($urandom), 1'b1, 1'b0);
		end
		send(8'($urandom), 1'b0, 1'b1);
	endtask

	// receiver: draw a wait after each word, hold off entirely when requested
	always @(posedge clk) begin
		int w;
		w = rx_wait;
		if (m_tvalid && m_tready)
			w = $urandom_range(0, 5);
		else if (w > 0)
			w = w - 1;
		rx_wait  <= w;
		m_tready <= (w == 0) && !long_hold;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !long_hold) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send(8'h00, 1'b0, 1'b1);
		send(8'hff, 1'b1, 1'b1);
		send(8'h00, 1'b1, 1'b0);
		send(8'h00, 1'b0, 1'b0);
		send(8'h61, 1'b1, 1'b1);
		send_message(55, 0);
		send_message(56, 0);
		for (int i = 0; i < 62; i++) send(8'($urandom), 1'b1, 1'b0);
		send(8'hab, 1'b1, 1'b1);
		// long output hold while the sender keeps offering
		fork
			begin
				long_hold = 1'b1;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end
			begin
				send_message(3, 0);
				send_message(70, 4);
			end
		join
		// random messages, mostly short
		sent = 0;
		while (sent < 70) begin
			int len;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 20);
			send_message(len, 3);
			sent += len + 1;
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sha_pkg.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_stream_hash.sv
bench/sha256_stream_hash_chk.sv
bench/sha256_stream_hash_tb.sv
